// ===== hw/rtl/snp_pkg.sv =====
// ----------------------------------------------------------------------------
// snp_pkg: shared types and constants for the shuffle and pairing block
// Sizes of the program population, register indexes, random stream constants
// and the request/response structs of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package snp_pkg;

  // Population and store sizes.
  localparam int unsigned MAX_PROGS  = 16384;
  localparam int unsigned PROG_W     = $clog2(MAX_PROGS);
  localparam int unsigned POP_W      = PROG_W + 1;
  localparam int unsigned PAIR_DEPTH = MAX_PROGS / 2;
  localparam int unsigned PAIR_W     = $clog2(PAIR_DEPTH);
  localparam int unsigned NPOP_W     = 21;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned GRID_W     = 8;
  localparam int unsigned NICHE_W    = 5;
  localparam int unsigned THR_W      = 54;
  localparam int unsigned EPOCH_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_W      = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_NICHE_COUNT = 3'd2,
    CFG_RNG_SEED    = 3'd3,
    CFG_LONG_THR    = 3'd4
  } cfg_index_e;

  // Command codes.
  localparam logic CMD_RUN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Random stream constants.
  localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2   = 64'h94D049BB133111EB;
  localparam logic [63:0] SEED_K     = 64'h0000000025_45F491;
  localparam logic [63:0] EPOCH_K    = 64'h00000100000001B3;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    AOP_MULADD = 2'd0,
    AOP_MIX    = 2'd1,
    AOP_DIV    = 2'd2
  } arith_op_e;

  typedef struct packed {
    logic             start;
    arith_op_e        op;
    logic [63:0]      a;
    logic [63:0]      b;
    logic [63:0]      c;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [63:0]      res;
    logic [POP_W-1:0] rem;
  } arith_rsp_t;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_PRE,
    AR_MUL,
    AR_X27,
    AR_X31,
    AR_DIV,
    AR_DONE
  } arith_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_CELL,
    ST_NPOP,
    ST_CHECK,
    ST_IDENT,
    ST_SEEDA,
    ST_SEEDB,
    ST_SEEDM,
    ST_SH_MIX,
    ST_SH_DIV,
    ST_SH_RD,
    ST_SH_WI,
    ST_SH_WJ,
    ST_FREE_CLR,
    ST_W_RDP,
    ST_W_RDF,
    ST_W_CHK,
    ST_W_MIXB,
    ST_W_JMIX,
    ST_W_JDIV,
    ST_W_NMIX,
    ST_W_NCELL,
    ST_W_NW,
    ST_W_NQ,
    ST_W_RDQ,
    ST_W_CHQ,
    ST_W_MARKQ,
    ST_W_NEXT,
    ST_FINISH
  } run_state_e;

endpackage

// ===== hw/rtl/snp_arith.sv =====
// ----------------------------------------------------------------------------
// snp_arith: shared multi-cycle arithmetic unit
// One 32x32 multiplier builds 64-bit low products piece by piece, used for
// multiply-add and for the splitmix64 step; a radix-16 restoring divider
// gives quotient and remainder of a 64-bit value by a narrow divisor.
// ----------------------------------------------------------------------------
module snp_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  snp_pkg::arith_req_t req_i,
  output snp_pkg::arith_rsp_t rsp_o
);
  import snp_pkg::*;

  arith_state_e     st_q, st_d;
  arith_op_e        op_q, op_d;
  logic [1:0]       mcnt_q, mcnt_d;
  logic [3:0]       dcnt_q, dcnt_d;
  logic             mix2_q, mix2_d;
  logic [63:0]      a_q, a_d, b_q, b_d, acc_q, acc_d, prod_q, prod_d, dvd_q, dvd_d;
  logic [POP_W-1:0] dvs_q, dvs_d, rem_q, rem_d;
  logic [31:0]      mul_a, mul_b;

  // Sequencer and datapath.
  always_comb begin
    logic [POP_W:0]   r;
    logic [POP_W-1:0] rr;
    logic [63:0]      qq;
    st_d   = st_q;
    op_d   = op_q;
    mcnt_d = mcnt_q;
    dcnt_d = dcnt_q;
    mix2_d = mix2_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    prod_d = prod_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    rsp_o.done = 1'b0;
    rsp_o.res  = (op_q == AOP_DIV) ? dvd_q : acc_q;
    rsp_o.rem  = rem_q;

    // Partial product operands: low x low, low x high, high x low.
    mul_a = (mcnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    mul_b = (mcnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];

    // Four restoring division steps, one quotient bit each.
    rr = rem_q;
    qq = dvd_q;
    for (int s = 0; s < 4; s++) begin
      r  = {rr, qq[63]};
      qq = {qq[62:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r     = r - {1'b0, dvs_q};
        qq[0] = 1'b1;
      end
      rr = r[POP_W-1:0];
    end

    unique case (st_q)
      AR_IDLE: begin
        if (req_i.start) begin
          op_d = req_i.op;
          unique case (req_i.op)
            AOP_MULADD: begin
              a_d    = req_i.a;
              b_d    = req_i.b;
              acc_d  = req_i.c;
              mcnt_d = 2'd0;
              st_d   = AR_MUL;
            end
            AOP_MIX: begin
              acc_d = req_i.a + MIX_GOLDEN;
              st_d  = AR_PRE;
            end
            AOP_DIV: begin
              dvd_d  = req_i.a;
              dvs_d  = req_i.b[POP_W-1:0];
              rem_d  = '0;
              dcnt_d = 4'd0;
              st_d   = AR_DIV;
            end
            default: st_d = AR_DONE;
          endcase
        end
      end
      AR_PRE: begin
        a_d    = acc_q ^ (acc_q >> 30);
        b_d    = MIX_MUL1;
        acc_d  = '0;
        mcnt_d = 2'd0;
        mix2_d = 1'b0;
        st_d   = AR_MUL;
      end
      AR_MUL: begin
        mcnt_d = mcnt_q + 2'd1;
        prod_d = mul_a * mul_b;
        unique case (mcnt_q)
          2'd0: acc_d = acc_q;
          2'd1: acc_d = acc_q + prod_q;
          default: acc_d = acc_q + (prod_q << 32);
        endcase
        if (mcnt_q == 2'd3) begin
          if (op_q == AOP_MIX) begin
            st_d = mix2_q ? AR_X31 : AR_X27;
          end else begin
            st_d = AR_DONE;
          end
        end
      end
      AR_X27: begin
        a_d    = acc_q ^ (acc_q >> 27);
        b_d    = MIX_MUL2;
        acc_d  = '0;
        mcnt_d = 2'd0;
        mix2_d = 1'b1;
        st_d   = AR_MUL;
      end
      AR_X31: begin
        acc_d = acc_q ^ (acc_q >> 31);
        st_d  = AR_DONE;
      end
      AR_DIV: begin
        dvd_d  = qq;
        rem_d  = rr;
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'd15) begin
          st_d = AR_DONE;
        end
      end
      AR_DONE: begin
        rsp_o.done = 1'b1;
        st_d       = AR_IDLE;
      end
      default: st_d = AR_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= AR_IDLE;
      op_q   <= AOP_MULADD;
      mcnt_q <= '0;
      dcnt_q <= '0;
      mix2_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      op_q   <= op_d;
      mcnt_q <= mcnt_d;
      dcnt_q <= dcnt_d;
      mix2_q <= mix2_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
  end

endmodule

// ===== hw/rtl/shuffle_and_neighbour_pairing.sv =====
// ----------------------------------------------------------------------------
// shuffle_and_neighbour_pairing: shuffled random and grid-neighbour pairing
// Runs a Fisher-Yates shuffle of a persistent permutation and a greedy pairing
// walk, drawing from a splitmix64 stream; read transactions return stored pairs.
// ----------------------------------------------------------------------------
// A refused run ends at the population check. A run of n programs rewrites the
// permutation to the identity when the population has changed, then shuffles it,
// clears the free marks and walks the shuffled order, skipping programs already
// taken; mix steps and divisions go through the shared arithmetic unit.
// One transaction at a time. Reset restores the configuration and control
// registers and an empty pair count.
module shuffle_and_neighbour_pairing (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [snp_pkg::EPOCH_W-1:0]     epoch_i,
  input  logic [snp_pkg::PAIR_W-1:0]      pair_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [snp_pkg::PROG_W-1:0]      pair_total_o,
  output logic [snp_pkg::PROG_W-1:0]      first_member_o,
  output logic [snp_pkg::PROG_W-1:0]      second_member_o,
  output logic                            config_error_o,
  input  logic                            cfg_we_i,
  input  logic [snp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [snp_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import snp_pkg::*;

  // Configuration registers.
  logic [GRID_W-1:0]  grid_width_q, grid_height_q;
  logic [NICHE_W-1:0] niche_count_q;
  logic [63:0]        rng_seed_q;
  logic [THR_W-1:0]   long_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_W'(128);
      grid_height_q <= GRID_W'(128);
      niche_count_q <= NICHE_W'(1);
      rng_seed_q    <= 64'd1;
      long_thr_q    <= 54'd450359962737050;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[GRID_W-1:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_NICHE_COUNT: niche_count_q <= cfg_wdata_i[NICHE_W-1:0];
        CFG_RNG_SEED:    rng_seed_q    <= cfg_wdata_i;
        CFG_LONG_THR:    long_thr_q    <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and working registers.
  run_state_e          st_q, st_d;
  logic                out_valid_q, out_valid_d;
  logic [PROG_W-1:0]   pair_counter_q, pair_counter_d;
  logic [POP_W-1:0]    last_pop_q, last_pop_d;
  logic [63:0]         stream_q, stream_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic [PROG_W-1:0]   idx_q, idx_d, j_q, j_d, p_q, p_d, q_q, q_d, pos_q, pos_d;
  logic [PROG_W-1:0]   tmp_q, tmp_d, cnt_q, cnt_d;
  logic [GRID_W-1:0]   x_q, x_d, y_q, y_d;
  logic [1:0]          dir_q, dir_d;
  logic [CELL_W-1:0]   cell_q, cell_d;
  logic [NPOP_W-1:0]   n_q, n_d;
  logic                rd_ok_q, rd_ok_d;
  logic [PROG_W-1:0]   first_q, first_d, second_q, second_d;
  logic                err_q, err_d;
  logic [PROG_W-1:0]   last_idx;
  logic [POP_W-1:0]    nb;
  logic                in_fire;

  arith_req_t          ar_req;
  arith_rsp_t          ar_rsp;

  // Memories and their ports.
  logic [PROG_W-1:0]   perm_mem [MAX_PROGS];
  logic                free_mem [MAX_PROGS];
  logic [PROG_W-1:0]   pf_mem   [PAIR_DEPTH];
  logic [PROG_W-1:0]   ps_mem   [PAIR_DEPTH];
  logic [PROG_W-1:0]   perm_rda_q, perm_rdb_q, pf_rd_q, ps_rd_q;
  logic                free_rd_q;
  logic                perm_we, free_we, free_wdata, pair_we;
  logic [PROG_W-1:0]   perm_waddr, perm_wdata, free_waddr, free_raddr;

  snp_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ar_req),
    .rsp_o  (ar_rsp)
  );

  assign in_ready_o = (st_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_idx   = PROG_W'(n_q - NPOP_W'(1));
  assign free_raddr = (st_q == ST_W_RDF) ? perm_rda_q : q_q;

  // Toroidal neighbour inside the program's niche, from its coordinates.
  always_comb begin
    unique case (dir_q)
      2'd0: nb = (x_q + GRID_W'(1) == grid_width_q) ?
                 POP_W'(p_q) - POP_W'(x_q) : POP_W'(p_q) + POP_W'(1);
      2'd1: nb = (x_q == '0) ?
                 POP_W'(p_q) + POP_W'(grid_width_q) - POP_W'(1) : POP_W'(p_q) - POP_W'(1);
      2'd2: nb = (y_q + GRID_W'(1) == grid_height_q) ?
                 POP_W'(p_q) - (POP_W'(pos_q) - POP_W'(x_q)) :
                 POP_W'(p_q) + POP_W'(grid_width_q);
      default: nb = (y_q == '0) ?
                 POP_W'(p_q) + POP_W'(cell_q) - POP_W'(grid_width_q) :
                 POP_W'(p_q) - POP_W'(grid_width_q);
    endcase
  end

  // Next state, arithmetic requests and memory writes.
  always_comb begin
    st_d           = st_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    pair_counter_d = pair_counter_q;
    last_pop_d     = last_pop_q;
    stream_d       = stream_q;
    epoch_d        = epoch_q;
    idx_d          = idx_q;
    j_d            = j_q;
    p_d            = p_q;
    q_d            = q_q;
    pos_d          = pos_q;
    tmp_d          = tmp_q;
    cnt_d          = cnt_q;
    x_d            = x_q;
    y_d            = y_q;
    dir_d          = dir_q;
    cell_d         = cell_q;
    n_d            = n_q;
    rd_ok_d        = rd_ok_q;
    first_d        = first_q;
    second_d       = second_q;
    err_d          = err_q;
    ar_req         = '0;
    ar_req.op      = AOP_MIX;
    ar_req.a       = stream_q;
    perm_we        = 1'b0;
    perm_waddr     = idx_q;
    perm_wdata     = idx_q;
    free_we        = 1'b0;
    free_waddr     = idx_q;
    free_wdata     = 1'b1;
    pair_we        = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd_i == CMD_READ) begin
            rd_ok_d = (PROG_W'(pair_index_i) < pair_counter_q);
            st_d    = ST_RD_WAIT;
          end else begin
            epoch_d = epoch_i;
            st_d    = ST_CELL;
          end
        end
      end
      ST_RD_WAIT: begin
        first_d     = rd_ok_q ? pf_rd_q : '0;
        second_d    = rd_ok_q ? ps_rd_q : '0;
        err_d       = 1'b0;
        out_valid_d = 1'b1;
        st_d        = ST_IDLE;
      end
      // Population size: cells per niche, then all niches.
      ST_CELL: begin
        ar_req.start = 1'b1;
        ar_req.op    = AOP_MULADD;
        ar_req.a     = 64'(grid_width_q);
        ar_req.b     = 64'(grid_height_q);
        if (ar_rsp.done) begin
          cell_d = ar_rsp.res[CELL_W-1:0];
          st_d   = ST_NPOP;
        end
      end
      ST_NPOP: begin
        ar_req.start = 1'b1;
        ar_req.op    = AOP_MULADD;
        ar_req.a     = 64'(cell_q);
        ar_req.b     = 64'(niche_count_q);
        if (ar_rsp.done) begin
          n_d  = ar_rsp.res[NPOP_W-1:0];
          st_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_q < NPOP_W'(2) || n_q > NPOP_W'(MAX_PROGS)) begin
          first_d     = '0;
          second_d    = '0;
          err_d       = 1'b1;
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end else begin
          last_pop_d = n_q[POP_W-1:0];
          idx_d      = '0;
          cnt_d      = '0;
          st_d       = (n_q[POP_W-1:0] != last_pop_q) ? ST_IDENT : ST_SEEDA;
        end
      end
      // A new population size starts again from the identity.
      ST_IDENT: begin
        perm_we = 1'b1;
        if (idx_q == last_idx) begin
          st_d = ST_SEEDA;
        end else begin
          idx_d = idx_q + PROG_W'(1);
        end
      end
      // Stream seed: mix(seed * K + epoch * K').
      ST_SEEDA: begin
        ar_req.start = 1'b1;
        ar_req.op    = AOP_MULADD;
        ar_req.a     = 64'(epoch_q);
        ar_req.b     = EPOCH_K;
        if (ar_rsp.done) begin
          stream_d = ar_rsp.res;
          st_d     = ST_SEEDB;
        end
      end
      ST_SEEDB: begin
        ar_req.start = 1'b1;
        ar_req.op    = AOP_MULADD;
        ar_req.a     = rng_seed_q;
        ar_req.b     = SEED_K;
        ar_req.c     = stream_q;
        if (ar_rsp.done) begin
          stream_d = ar_rsp.res;
          st_d     = ST_SEEDM;
        end
      end
      ST_SEEDM: begin
        ar_req.start = 1'b1;
        if (ar_rsp.done) begin
          stream_d = ar_rsp.res;
          idx_d    = last_idx;
          st_d     = ST_SH_MIX;
        end
      end
      // Fisher-Yates step: j = draw mod (i + 1), swap entries i and j.
      ST_SH_MIX: begin
        ar_req.start = 1'b1;
        if (ar_rsp.done) begin
          stream_d = ar_rsp.res;
          st_d     = ST_SH_DIV;
        end
      end
      ST_SH_DIV: begin
        ar_req.start = 1'b1;
        ar_req.op    = AOP_DIV;
        ar_req.b     = 64'(idx_q) + 64'd1;
        if (ar_rsp.done) begin
          j_d  = ar_rsp.rem[PROG_W-1:0];
          st_d = ST_SH_RD;
        end
      end
      ST_SH_RD: st_d = ST_SH_WI;
      ST_SH_WI: begin
        perm_we    = 1'b1;
        perm_wdata = perm_rdb_q;
        tmp_d      = perm_rda_q;
        st_d       = ST_SH_WJ;
      end
      ST_SH_WJ: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = tmp_q;
        if (idx_q == PROG_W'(1)) begin
          idx_d = '0;
          st_d  = ST_FREE_CLR;
        end else begin
          idx_d = idx_q - PROG_W'(1);
          st_d  = ST_SH_MIX;
        end
      end
      ST_FREE_CLR: begin
        free_we = 1'b1;
        if (idx_q == last_idx) begin
          idx_d = '0;
          st_d  = ST_W_RDP;
        end else begin
          idx_d = idx_q + PROG_W'(1);
        end
      end
      // Pairing walk over the shuffled order.
      ST_W_RDP: st_d = ST_W_RDF;
      ST_W_RDF: begin
        p_d  = perm_rda_q;
        st_d = ST_W_CHK;
      end
      ST_W_CHK: st_d = free_rd_q ? ST_W_MIXB : ST_W_NEXT;
      ST_W_MIXB: begin
        ar_req.start = 1'b1;
        if (ar_rsp.done) begin
          stream_d = ar_rsp.res;
          st_d     = ({1'b0, ar_rsp.res[63:11]} < long_thr_q) ? ST_W_JMIX : ST_W_NMIX;
        end
      end
      ST_W_JMIX: begin
        ar_req.start = 1'b1;
        if (ar_rsp.done) begin
          stream_d = ar_rsp.res;
          st_d     = ST_W_JDIV;
        end
      end
      ST_W_JDIV: begin
        ar_req.start = 1'b1;
        ar_req.op    = AOP_DIV;
        ar_req.b     = 64'(n_q);
        if (ar_rsp.done) begin
          q_d  = ar_rsp.rem[PROG_W-1:0];
          st_d = ST_W_RDQ;
        end
      end
      ST_W_NMIX: begin
        ar_req.start = 1'b1;
        if (ar_rsp.done) begin
          stream_d = ar_rsp.res;
          dir_d    = ar_rsp.res[1:0];
          st_d     = ST_W_NCELL;
        end
      end
      // Position inside the niche, then column and row.
      ST_W_NCELL: begin
        ar_req.start = 1'b1;
        ar_req.op    = AOP_DIV;
        ar_req.a     = 64'(p_q);
        ar_req.b     = 64'(cell_q);
        if (ar_rsp.done) begin
          pos_d = ar_rsp.rem[PROG_W-1:0];
          st_d  = ST_W_NW;
        end
      end
      ST_W_NW: begin
        ar_req.start = 1'b1;
        ar_req.op    = AOP_DIV;
        ar_req.a     = 64'(pos_q);
        ar_req.b     = 64'(grid_width_q);
        if (ar_rsp.done) begin
          x_d  = ar_rsp.rem[GRID_W-1:0];
          y_d  = ar_rsp.res[GRID_W-1:0];
          st_d = ST_W_NQ;
        end
      end
      ST_W_NQ: begin
        q_d  = nb[PROG_W-1:0];
        st_d = ST_W_RDQ;
      end
      ST_W_RDQ: st_d = ST_W_CHQ;
      ST_W_CHQ: begin
        if (q_q != p_q && free_rd_q) begin
          free_we    = 1'b1;
          free_waddr = p_q;
          free_wdata = 1'b0;
          if (cnt_q < PROG_W'(PAIR_DEPTH)) begin
            pair_we = 1'b1;
            cnt_d   = cnt_q + PROG_W'(1);
          end
          st_d = ST_W_MARKQ;
        end else begin
          st_d = ST_W_NEXT;
        end
      end
      ST_W_MARKQ: begin
        free_we    = 1'b1;
        free_waddr = q_q;
        free_wdata = 1'b0;
        st_d       = ST_W_NEXT;
      end
      ST_W_NEXT: begin
        if (idx_q == last_idx) begin
          st_d = ST_FINISH;
        end else begin
          idx_d = idx_q + PROG_W'(1);
          st_d  = ST_W_RDP;
        end
      end
      ST_FINISH: begin
        pair_counter_d = cnt_q;
        first_d        = '0;
        second_d       = '0;
        err_d          = 1'b0;
        out_valid_d    = 1'b1;
        st_d           = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= ST_IDLE;
      out_valid_q    <= 1'b0;
      pair_counter_q <= '0;
      last_pop_q     <= '0;
      stream_q       <= '0;
    end else begin
      st_q           <= st_d;
      out_valid_q    <= out_valid_d;
      pair_counter_q <= pair_counter_d;
      last_pop_q     <= last_pop_d;
      stream_q       <= stream_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    epoch_q  <= epoch_d;
    idx_q    <= idx_d;
    j_q      <= j_d;
    p_q      <= p_d;
    q_q      <= q_d;
    pos_q    <= pos_d;
    tmp_q    <= tmp_d;
    cnt_q    <= cnt_d;
    x_q      <= x_d;
    y_q      <= y_d;
    dir_q    <= dir_d;
    cell_q   <= cell_d;
    n_q      <= n_d;
    rd_ok_q  <= rd_ok_d;
    first_q  <= first_d;
    second_q <= second_d;
    err_q    <= err_d;
  end

  // Permutation memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rda_q <= perm_mem[idx_q];
    perm_rdb_q <= perm_mem[j_q];
  end

  // Free marks.
  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    free_rd_q <= free_mem[free_raddr];
  end

  // Pair stores, written during a run and read by read transactions.
  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pf_mem[cnt_q[PAIR_W-1:0]] <= p_q;
      ps_mem[cnt_q[PAIR_W-1:0]] <= q_q;
    end
    pf_rd_q <= pf_mem[pair_index_i];
    ps_rd_q <= ps_mem[pair_index_i];
  end

  assign out_valid_o     = out_valid_q;
  assign pair_total_o    = pair_counter_q;
  assign first_member_o  = first_q;
  assign second_member_o = second_q;
  assign config_error_o  = err_q;

  // A completed run never forms more pairs than half the population.
  a_pairs_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FINISH) |=> (NPOP_W'(pair_counter_q) <= (n_q >> 1)))
    else $error("pair count exceeds half the population");

  // The swap partner never lies above the current shuffle position.
  a_swap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SH_RD) |-> (j_q <= idx_q))
    else $error("shuffle partner out of range");

  // A candidate partner always lies inside the population.
  a_partner_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_W_CHQ) |-> (NPOP_W'(q_q) < n_q))
    else $error("partner outside the population");

  // An accepted transaction clears the output slot until its result is ready.
  a_out_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !out_valid_q)
    else $error("stale result after accepting a transaction");

endmodule

// ===== tb/snp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_checker: scoreboard for the shuffle and pairing block
// Watches the input, output and register write channels, keeps its own copy
// of the permutation, pair stores and random stream, and compares each result
// transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module snp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          cmd_i,
  input  logic [snp_pkg::EPOCH_W-1:0]   epoch_i,
  input  logic [snp_pkg::PAIR_W-1:0]    pair_index_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [snp_pkg::PROG_W-1:0]    pair_total_i,
  input  logic [snp_pkg::PROG_W-1:0]    first_member_i,
  input  logic [snp_pkg::PROG_W-1:0]    second_member_i,
  input  logic                          config_error_i,
  input  logic                          cfg_we_i,
  input  logic [snp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [snp_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            pair_count_o,
  output int                            runs_o,
  output int                            refused_o,
  output int                            reads_o
);
  import snp_pkg::*;

  typedef struct packed {
    logic [PROG_W-1:0] total;
    logic [PROG_W-1:0] first;
    logic [PROG_W-1:0] second;
    logic              err;
  } pair_result_t;

  // Register copies, at their reset values.
  logic [7:0]       width_q  = 8'd128;
  logic [7:0]       height_q = 8'd128;
  logic [4:0]       niches_q = 5'd1;
  logic [63:0]      seed_q   = 64'd1;
  logic [THR_W-1:0] thr_q    = 54'd450359962737050;

  // Block state as seen from outside.
  logic [PROG_W-1:0] perm [MAX_PROGS];
  logic              is_free [MAX_PROGS];
  logic [PROG_W-1:0] first_store [PAIR_DEPTH];
  logic [PROG_W-1:0] second_store [PAIR_DEPTH];
  int unsigned       pairs_formed;
  int unsigned       prev_pop;
  logic [63:0]       stream;

  pair_result_t expected_pairs[$];

  initial begin
    for (int i = 0; i < MAX_PROGS; i++) perm[i] = PROG_W'(i);
    pairs_formed = 0;
    prev_pop     = 0;
    stream       = '0;
    fail_count_o = 0;
    runs_o       = 0;
    refused_o    = 0;
    reads_o      = 0;
  end

  assign pending_o    = expected_pairs.size();
  assign pair_count_o = pairs_formed;

  function automatic logic [63:0] splitmix(input logic [63:0] v);
    logic [63:0] x;
    x = v + MIX_GOLDEN;
    x = (x ^ (x >> 30)) * MIX_MUL1;
    x = (x ^ (x >> 27)) * MIX_MUL2;
    return x ^ (x >> 31);
  endfunction

  function automatic logic [63:0] next_draw();
    stream = splitmix(stream);
    return stream;
  endfunction

  // Neighbour of p in direction d, wrapping inside p's own niche.
  function automatic int unsigned neighbour(input int unsigned p, input int unsigned d,
                                            input int unsigned w, input int unsigned h);
    int unsigned area, base, x, y;
    area = w * h;
    base = (p / area) * area;
    x = (p - base) % w;
    y = (p - base) / w;
    case (d)
      0: x = (x + 1) % w;
      1: x = (x + w - 1) % w;
      2: y = (y + 1) % h;
      default: y = (y + h - 1) % h;
    endcase
    return base + y * w + x;
  endfunction

  // Predicted result of a read, a refused run or a shuffle and pairing run.
  function automatic pair_result_t predict_pairing(input logic cmd,
                                                   input logic [EPOCH_W-1:0] ep,
                                                   input logic [PAIR_W-1:0] idx);
    pair_result_t res;
    int unsigned  n, j, p, q, cnt;
    logic [PROG_W-1:0] t;
    res = '0;
    if (cmd == CMD_READ) begin
      if (idx < pairs_formed) begin
        res.first  = first_store[idx];
        res.second = second_store[idx];
      end
    end else begin
      n = int'(width_q) * int'(height_q) * int'(niches_q);
      if (n < 2 || n > MAX_PROGS) begin
        res.err = 1'b1;
      end else begin
        if (n != prev_pop)
          for (int i = 0; i < MAX_PROGS; i++) perm[i] = PROG_W'(i);
        prev_pop = n;
        stream = splitmix(seed_q * SEED_K + {32'd0, ep} * EPOCH_K);
        for (int i = n - 1; i > 0; i--) begin
          j = int'(next_draw() % 64'(i + 1));
          t = perm[i];
          perm[i] = perm[j];
          perm[j] = t;
        end
        for (int i = 0; i < MAX_PROGS; i++) is_free[i] = 1'b1;
        cnt = 0;
        for (int k = 0; k < n; k++) begin
          p = perm[k];
          if (!is_free[p]) continue;
          if ((next_draw() >> 11) < {10'd0, thr_q})
            q = int'(next_draw() % 64'(n));
          else
            q = neighbour(p, int'(next_draw() % 64'd4), width_q, height_q);
          if (q == p || !is_free[q]) continue;
          is_free[p] = 1'b0;
          is_free[q] = 1'b0;
          if (cnt < PAIR_DEPTH) begin
            first_store[cnt]  = PROG_W'(p);
            second_store[cnt] = PROG_W'(q);
            cnt++;
          end
        end
        pairs_formed = cnt;
      end
    end
    res.total = PROG_W'(pairs_formed);
    return res;
  endfunction

  // Register writes, input transactions and result transactions.
  always @(posedge clk_i) begin
    pair_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GRID_WIDTH:  width_q  = cfg_wdata_i[7:0];
          CFG_GRID_HEIGHT: height_q = cfg_wdata_i[7:0];
          CFG_NICHE_COUNT: niches_q = cfg_wdata_i[4:0];
          CFG_RNG_SEED:    seed_q   = cfg_wdata_i;
          CFG_LONG_THR:    thr_q    = cfg_wdata_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: result transaction with nothing expected: total %0d pair %0d/%0d err %0b",
                   $time, pair_total_i, first_member_i, second_member_i, config_error_i);
          fail_count_o++;
        end else begin
          want = expected_pairs.pop_front();
          if (want.total !== pair_total_i) begin
            $display("%0t: pair_total expected %0d actual %0d", $time, want.total, pair_total_i);
            fail_count_o++;
          end
          if (want.first !== first_member_i) begin
            $display("%0t: first_member expected %0d actual %0d",
                     $time, want.first, first_member_i);
            fail_count_o++;
          end
          if (want.second !== second_member_i) begin
            $display("%0t: second_member expected %0d actual %0d",
                     $time, want.second, second_member_i);
            fail_count_o++;
          end
          if (want.err !== config_error_i) begin
            $display("%0t: config_error expected %0b actual %0b",
                     $time, want.err, config_error_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = predict_pairing(cmd_i, epoch_i, pair_index_i);
        expected_pairs.push_back(want);
        if (cmd_i == CMD_READ) reads_o++;
        else if (want.err) refused_o++;
        else runs_o++;
      end
    end
  end

endmodule

// ===== tb/tb_shuffle_and_neighbour_pairing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shuffle_and_neighbour_pairing: testbench top for the pairing block
// Drives register settings, run and read transactions with random gaps and
// output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_shuffle_and_neighbour_pairing;
  import snp_pkg::*;

  // Index past the end of the register list; writes to it are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
  localparam logic [THR_W-1:0]     THR_ALWAYS = 54'd9007199254740992;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 cmd_i = CMD_READ;
  logic [EPOCH_W-1:0]   epoch_i = '0;
  logic [PAIR_W-1:0]    pair_index_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PROG_W-1:0]    pair_total_o, first_member_o, second_member_o;
  logic                 config_error_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_GRID_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  int fail_count, pending, pair_count, runs, refused, reads;
  bit steady = 1'b0;
  int stall_left = 0;

  always #10 clk_i = ~clk_i;

  shuffle_and_neighbour_pairing DUT (.*);

  snp_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .epoch_i,
    .pair_index_i, .out_valid_i(out_valid_o), .out_ready_i,
    .pair_total_i(pair_total_o), .first_member_i(first_member_o),
    .second_member_i(second_member_o), .config_error_i(config_error_o),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending), .pair_count_o(pair_count),
    .runs_o(runs), .refused_o(refused), .reads_o(reads)
  );

  // Mostly short gaps, now and then a long one; none during steady stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (steady || $urandom_range(0, 9) < 7) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      stall_left  <= pick_gap();
    end
  end

  task automatic send_item(input logic cmd, input logic [EPOCH_W-1:0] ep,
                           input logic [PAIR_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    epoch_i      <= ep;
    pair_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Wait until every result is back and the block has settled.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                          input logic [CFG_W-1:0] nc, input logic [CFG_W-1:0] seed,
                          input logic [CFG_W-1:0] thr);
    logic [CFG_W-1:0] vals [5];
    cfg_index_e       regs [5];
    settle();
    vals = '{w, h, nc, seed, thr};
    regs = '{CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_NICHE_COUNT, CFG_RNG_SEED, CFG_LONG_THR};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic read_pair(input logic [PAIR_W-1:0] idx);
    send_item(CMD_READ, {$urandom}, idx);
  endtask

  task automatic read_some();
    logic [PAIR_W-1:0] idx;
    if (pair_count > 0 && $urandom_range(0, 9) < 8)
      idx = PAIR_W'($urandom_range(0, pair_count - 1));
    else idx = PAIR_W'($urandom);
    read_pair(idx);
  endtask

  // Stimulus.
  initial begin
    logic [CFG_W-1:0] thr;
    int t;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads before any run answer zeros.
    read_pair('0);
    read_pair('1);
    set_regs({56'hA5A5_A5A5_A5A5_A5, 8'd4}, 4, 1, 1, 64'd450359962737050);
    send_item(CMD_RUN, '0, '0);
    send_item(CMD_RUN, '1, '0);
    read_pair('0);
    read_pair(1);
    read_pair('1);
    set_regs(5, 3, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_item(CMD_RUN, 32'h1234_5678, '0);
    read_pair(2);
    set_regs(3, 5, 3, 64'd0, {THR_ALWAYS});
    send_item(CMD_RUN, 32'h8000_0001, '0);
    read_pair(0);
    // Populations too small and too large are refused.
    set_regs(1, 1, 1, 7, 64'h3F_FFFF_FFFF_FFFF);
    send_item(CMD_RUN, 9, '0);
    read_pair(0);
    set_regs(128, 128, 2, 7, 64'h3F_FFFF_FFFF_FFFF);
    send_item(CMD_RUN, 9, '0);
    set_regs(128, 1, 1, 11, 64'h10_0000_0000_0000);
    send_item(CMD_RUN, 3, '0);
    set_regs(1, 128, 1, 11, 64'h8_0000_0000);
    send_item(CMD_RUN, 4, '0);
    set_regs(2, 2, 16, 13, 64'd450359962737050);
    send_item(CMD_RUN, 5, '0);
    read_pair(31);
    set_regs(255, 1, 1, 17, 64'd450359962737050);
    send_item(CMD_RUN, 6, '0);
    // A large population, run twice so the kept permutation is reshuffled.
    set_regs(32, 32, 1, 19, 64'd1000000000000000);
    send_item(CMD_RUN, 7, '0);
    send_item(CMD_RUN, 8, '0);
    read_pair(PAIR_W'(pair_count - 1));
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_UNUSED;
    cfg_wdata_i <= '1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    read_pair(0);

    // Random phases: small grids, new settings between phases.
    for (int ph = 0; ph < 10; ph++) begin
      t = $urandom_range(0, 3);
      thr = (t == 0) ? 64'd0 : (t == 1) ? {10'd0, THR_ALWAYS} :
            (t == 2) ? {10'd0, 54'($urandom_range(0, 1 << 30)) << 22}
                     : {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) set_regs(1, 1, 1, {$urandom, $urandom}, thr);
      else set_regs(64'($urandom_range(1, 8)), 64'($urandom_range(1, 8)),
                    64'($urandom_range(1, 4)), {$urandom, $urandom}, thr);
      steady = (ph % 4 == 3);
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 9) < 3) send_item(CMD_RUN, $urandom, PAIR_W'($urandom));
        else read_some();
      end
      steady = 1'b0;
    end

    settle();
    $display("Covered %0d pairing runs, %0d refused runs and %0d reads,", runs, refused, reads);
    $display("with gaps and output stalls over several grid and threshold settings.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1_200_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("status: fail");
    $finish;
  end

endmodule
